// ===== design/suim_pkg.sv =====
`timescale 1ns / 1ps

package suim_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned KIND_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_UNION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNION,
    ST_INTER,
    ST_END
  } state_t;

  // result of the shared signed compare
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

endpackage

// ===== design/suim_store.sv =====
`timescale 1ns / 1ps

// One list: single write port, single read port with registered data.
module suim_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [IDX_W-1:0]              waddr,
  input  logic [suim_pkg::DATA_W-1:0]   wdata,
  input  logic [IDX_W-1:0]              raddr,
  output logic [suim_pkg::DATA_W-1:0]   rdata
);

  logic [suim_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/suim_cmp.sv =====
`timescale 1ns / 1ps

// Shared signed comparator used by both merge passes.
module suim_cmp (
  input  logic [suim_pkg::DATA_W-1:0] a,
  input  logic [suim_pkg::DATA_W-1:0] b,
  output suim_pkg::cmp_t              res
);

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.gt = $signed(b) < $signed(a);
  end

endmodule

// ===== design/sorted_union_intersection.sv =====
`timescale 1ns / 1ps
// Load beats (append to list A or B) are accepted back to back while the block is idle.
// A start beat runs the merge: the union pass emits one result per step, then both
// pointers rewind; each intersection step advances ia, ib or both, emitting on equal
// heads; a last step leaves the intersection pass, and then the end marker is emitted.
// Input is not ready while a run is in progress. Output stalls hold the sequencer.
// Reset (rst, synchronous) clears both counts, the sequencer and the output valid.
module sorted_union_intersection #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic [1:0]  s_tuser,  // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] result_value
  output logic [1:0]  m_tuser,  // [1:0] kind
  output logic        m_tlast
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  suim_pkg::state_t state, state_next;

  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic [CNT_W-1:0] ia, ib, ia_next, ib_next;

  logic [suim_pkg::DATA_W-1:0] a_head, b_head;
  suim_pkg::cmp_t              cmp;

  logic                        s_beat, go, has_a, has_b, clr;
  logic                        we_a, we_b;
  logic                        emit, emit_last;
  logic [suim_pkg::KIND_W-1:0] emit_kind;
  logic [suim_pkg::DATA_W-1:0] emit_val;

  assign s_tready = (state == suim_pkg::ST_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign go       = !m_tvalid || m_tready;
  assign has_a    = ia < cnt_a;
  assign has_b    = ib < cnt_b;

  assign we_a = s_beat && (s_tuser == suim_pkg::OP_LOAD_A) && (cnt_a < CNT_W'(DEPTH));
  assign we_b = s_beat && (s_tuser == suim_pkg::OP_LOAD_B) && (cnt_b < CNT_W'(DEPTH));

  // reads are addressed by the next pointer, so the head is valid when the pointer lands
  suim_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[IDX_W-1:0]),
    .wdata (s_tdata),
    .raddr (ia_next[IDX_W-1:0]),
    .rdata (a_head)
  );

  suim_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[IDX_W-1:0]),
    .wdata (s_tdata),
    .raddr (ib_next[IDX_W-1:0]),
    .rdata (b_head)
  );

  suim_cmp u_cmp (
    .a   (a_head),
    .b   (b_head),
    .res (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      suim_pkg::ST_IDLE: begin
        if (s_beat && s_tuser == suim_pkg::OP_START) begin
          state_next = suim_pkg::ST_UNION;
        end
      end
      suim_pkg::ST_UNION: begin
        if (go && !has_a && !has_b) begin
          state_next = suim_pkg::ST_INTER;
        end
      end
      suim_pkg::ST_INTER: begin
        if (go && !(has_a && has_b)) begin
          state_next = suim_pkg::ST_END;
        end
      end
      suim_pkg::ST_END: begin
        if (go) begin
          state_next = suim_pkg::ST_IDLE;
        end
      end
      default: state_next = suim_pkg::ST_IDLE;
    endcase
  end

  // merge step: one compare per cycle while the output is not stalled
  always_comb begin
    emit      = 1'b0;
    emit_kind = suim_pkg::KIND_UNION;
    emit_val  = '0;
    emit_last = 1'b0;
    ia_next   = ia;
    ib_next   = ib;
    clr       = 1'b0;
    case (state)
      suim_pkg::ST_UNION: begin
        if (go) begin
          if (has_a && has_b) begin
            emit = 1'b1;
            if (cmp.lt) begin
              emit_val = a_head;
              ia_next  = ia + CNT_W'(1);
            end else if (cmp.gt) begin
              emit_val = b_head;
              ib_next  = ib + CNT_W'(1);
            end else begin
              emit_val = b_head;
              ia_next  = ia + CNT_W'(1);
              ib_next  = ib + CNT_W'(1);
            end
          end else if (has_a) begin
            emit     = 1'b1;
            emit_val = a_head;
            ia_next  = ia + CNT_W'(1);
          end else if (has_b) begin
            emit     = 1'b1;
            emit_val = b_head;
            ib_next  = ib + CNT_W'(1);
          end else begin
            // rewind both pointers for the intersection pass
            ia_next = '0;
            ib_next = '0;
          end
        end
      end
      suim_pkg::ST_INTER: begin
        if (go && has_a && has_b) begin
          if (cmp.lt) begin
            ia_next = ia + CNT_W'(1);
          end else if (cmp.gt) begin
            ib_next = ib + CNT_W'(1);
          end else begin
            emit      = 1'b1;
            emit_kind = suim_pkg::KIND_INTER;
            emit_val  = b_head;
            ia_next   = ia + CNT_W'(1);
            ib_next   = ib + CNT_W'(1);
          end
        end
      end
      suim_pkg::ST_END: begin
        if (go) begin
          emit      = 1'b1;
          emit_kind = suim_pkg::KIND_END;
          emit_last = 1'b1;
          clr       = 1'b1;
        end
      end
      default: begin
        if (s_beat && s_tuser == suim_pkg::OP_START) begin
          ia_next = '0;
          ib_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= suim_pkg::ST_IDLE;
      cnt_a    <= '0;
      cnt_b    <= '0;
      ia       <= '0;
      ib       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ia    <= ia_next;
      ib    <= ib_next;
      if (clr) begin
        cnt_a <= '0;
        cnt_b <= '0;
      end else begin
        if (we_a) begin
          cnt_a <= cnt_a + CNT_W'(1);
        end
        if (we_b) begin
          cnt_b <= cnt_b + CNT_W'(1);
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_val;
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import suim_pkg::*;

localparam int LIST_DEPTH = 16;
localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct {
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] value;
  logic              last;
} merge_result_t;

// Shadow copy of both lists; a start beat turns them into the union,
// intersection and end-marker beats the block should emit.
class merge_scoreboard;
  logic [DATA_W-1:0] list_a [LIST_DEPTH];
  logic [DATA_W-1:0] list_b [LIST_DEPTH];
  int unsigned count_a = 0;
  int unsigned count_b = 0;
  merge_result_t merge_q[$];
  int errors = 0;

  function void push_merge(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                           logic last);
    merge_result_t r;
    r.kind = kind;
    r.value = value;
    r.last = last;
    merge_q.push_back(r);
  endfunction

  function void note_input(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
    int unsigned i;
    int unsigned j;
    if (op == OP_LOAD_A) begin
      if (count_a < LIST_DEPTH) begin
        list_a[count_a] = value;
        count_a++;
      end
    end else if (op == OP_LOAD_B) begin
      if (count_b < LIST_DEPTH) begin
        list_b[count_b] = value;
        count_b++;
      end
    end else if (op == OP_START) begin
      i = 0;
      j = 0;
      while (i < count_a && j < count_b) begin
        if ($signed(list_a[i]) < $signed(list_b[j])) begin
          push_merge(KIND_UNION, list_a[i], 1'b0);
          i++;
        end else if ($signed(list_b[j]) < $signed(list_a[i])) begin
          push_merge(KIND_UNION, list_b[j], 1'b0);
          j++;
        end else begin
          push_merge(KIND_UNION, list_b[j], 1'b0);
          i++;
          j++;
        end
      end
      for (; i < count_a; i++) push_merge(KIND_UNION, list_a[i], 1'b0);
      for (; j < count_b; j++) push_merge(KIND_UNION, list_b[j], 1'b0);
      i = 0;
      j = 0;
      while (i < count_a && j < count_b) begin
        if ($signed(list_a[i]) < $signed(list_b[j])) begin
          i++;
        end else if ($signed(list_b[j]) < $signed(list_a[i])) begin
          j++;
        end else begin
          push_merge(KIND_INTER, list_b[j], 1'b0);
          i++;
          j++;
        end
      end
      push_merge(KIND_END, '0, 1'b1);
      count_a = 0;
      count_b = 0;
    end
  endfunction

  function void check_result(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                             logic last);
    merge_result_t want;
    if (merge_q.size() == 0) begin
      $display("%0t: unexpected beat kind %0d value %08h last %0b",
               $time, kind, value, last);
      errors++;
      return;
    end
    want = merge_q.pop_front();
    if (want.kind !== kind || want.value !== value || want.last !== last) begin
      $display("%0t: expected kind %0d value %08h last %0b, got kind %0d value %08h last %0b",
               $time, want.kind, want.value, want.last, kind, value, last);
      errors++;
    end
  endfunction

  function int pending();
    return merge_q.size();
  endfunction
endclass

module tb_top;
  localparam int TOTAL_ITEMS = 410;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]   s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic              m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  merge_scoreboard sb = new;

  always #2 clk = ~clk;

  sorted_union_intersection #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_union_intersection: mismatch");
      $finish;
    end
  end

  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, value);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // One load-and-merge run: two lists (usually ascending) loaded in random
  // interleave, a stray unused opcode now and then, and a start beat.
  task automatic random_run();
    int qa[$];
    int qb[$];
    int na;
    int nb;
    int ka;
    int kb;
    int base;
    int unsigned span;
    bit pick_a;
    case ($urandom_range(7))
      0: begin
        na = $urandom_range(15, 18);
        nb = $urandom_range(15, 18);
      end
      1: begin
        na = $urandom_range(0, 1);
        nb = $urandom_range(0, 6);
      end
      default: begin
        na = $urandom_range(0, 8);
        nb = $urandom_range(0, 8);
      end
    endcase
    base = $urandom;
    // narrow spans give plenty of equal heads for the intersection
    span = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(4, 60);
    repeat (na) qa.push_back(base + int'($urandom_range(span, 0)));
    repeat (nb) qb.push_back(base + int'($urandom_range(span, 0)));
    if ($urandom_range(9) != 0) begin
      qa.sort();
      qb.sort();
    end
    ka = 0;
    kb = 0;
    while (ka < qa.size() || kb < qb.size()) begin
      if ($urandom_range(19) == 0) send_beat(OP_UNUSED, $urandom);
      pick_a = (kb == qb.size()) || (ka < qa.size() && $urandom_range(1) == 1);
      if (pick_a) begin
        send_beat(OP_LOAD_A, qa[ka]);
        ka++;
      end else begin
        send_beat(OP_LOAD_B, qb[kb]);
        kb++;
      end
    end
    send_beat(OP_START, $urandom);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty lists: end marker only
    send_beat(OP_START, 32'h0000_0000);
    // signed extremes, shared min and max, -1 only in B
    send_beat(OP_LOAD_A, 32'h8000_0000);
    send_beat(OP_LOAD_B, 32'h8000_0000);
    send_beat(OP_LOAD_B, 32'hFFFF_FFFF);
    send_beat(OP_LOAD_A, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_B, 32'h7FFF_FFFF);
    send_beat(OP_START, 32'hFFFF_FFFF);
    // unused opcode is dropped
    send_beat(OP_UNUSED, 32'hFFFF_FFFF);
    // unsorted A with B empty: A tail as loaded
    send_beat(OP_LOAD_A, 32'd3);
    send_beat(OP_LOAD_A, 32'd1);
    send_beat(OP_START, 32'h5555_5555);
    // B only
    send_beat(OP_LOAD_B, 32'd7);
    send_beat(OP_START, 32'hAAAA_AAAA);

    while (items_sent < TOTAL_ITEMS) begin
      case (items_sent * 4 / TOTAL_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      random_run();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * LIST_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_union_intersection: match");
    end else begin
      $display("sorted_union_intersection: mismatch");
    end
    $finish;
  end
endmodule
